@@ src/iqt_pkg.sv @@
// Shared types, constants and helpers for the input qualification tick block.
`timescale 1ns / 1ps

package iqt_pkg;

	// Effective status codes
	localparam logic [4:0] ST_OK       = 5'd0;
	localparam logic [4:0] ST_DISABLED = 5'd1;
	localparam logic [4:0] ST_LOS      = 5'd2;

	typedef enum logic [1:0] {
		QM_IGNORE = 2'd0,
		QM_DISQ   = 2'd1,
		QM_OK     = 2'd2
	} qual_mode_t;

	typedef enum logic [2:0] {
		REG_INPUT_VALID      = 3'd0,
		REG_INPUT_ENABLE     = 3'd1,
		REG_NO_STANDBY_INPUT = 3'd2,
		REG_CARD_ACTIVE      = 3'd3,
		REG_CHANNEL_NUMBER   = 3'd4,
		REG_QUALIFY_DELAY    = 3'd5,
		REG_DISQUALIFY_DELAY = 3'd6
	} cfg_reg_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int DELAY_RESET = 10;

	localparam logic [14:0] PHASE_TOP     = 15'h7000;
	localparam logic [14:0] PHASE_RESTART = 15'h0700;
	localparam logic [14:0] PHASE_MASK    = 15'h0fff;

	localparam logic [7:0] CC_RESET        = 8'd1;
	localparam logic [7:0] CC_ENABLE_WRITE = 8'd10;
	localparam logic [7:0] CC_DELAY_WRITE  = 8'd1;
	localparam logic [7:0] CW_STATUS_CHG   = 8'h02;
	localparam logic [7:0] CW_QUAL_CHG     = 8'h01;

	typedef struct packed {
		logic [4:0] raw_status;
		logic       is_active_input;
	} iqt_in_t;

	typedef struct packed {
		logic [4:0] status;
		logic [1:0] qual_state;
		logic [7:0] change_word;
	} iqt_out_t;

	typedef struct packed {
		logic       input_valid;
		logic       input_enable;
		logic       no_standby_input;
		logic       card_active;
		logic [3:0] channel_number;
	} iqt_cfg_t;

	// Side effects of a configuration transaction on the qualifier state
	typedef struct packed {
		logic enable_write;
		logic enabled_after;
		logic qual_delay_write;
		logic disq_delay_write;
	} iqt_cfg_evt_t;

	typedef struct packed {
		logic [4:0]  last_status;
		qual_mode_t  qual_mode;
		logic [7:0]  change_count;
		logic [14:0] phase_count;
	} iqt_state_t;

	function automatic logic [7:0] sat_inc(logic [7:0] v);
		return (v == 8'hff) ? v : v + 8'd1;
	endfunction

endpackage

@@ src/iqt_cfg.sv @@
// Configuration register file with change detection for the qualifier.
`timescale 1ns / 1ps

module iqt_cfg #(
	parameter int DELAY_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [iqt_pkg::CFG_INDEX_W-1:0]      wr_index,
	input  logic [iqt_pkg::CFG_DATA_W-1:0]       wr_data,
	output iqt_pkg::iqt_cfg_t                    cfg,
	output logic [DELAY_BITS-1:0]                qual_delay,
	output logic [DELAY_BITS-1:0]                disq_delay,
	output logic [DELAY_BITS-1:0]                delay_wdata,
	output iqt_pkg::iqt_cfg_evt_t                evt
);

	iqt_pkg::iqt_cfg_t       cfg_q;
	logic [DELAY_BITS-1:0]   qual_delay_q;
	logic [DELAY_BITS-1:0]   disq_delay_q;
	logic                    bit_w;
	logic                    new_valid;
	logic                    new_enable;

	assign bit_w       = wr_data[0];
	assign delay_wdata = DELAY_BITS'(wr_data);

	always_comb begin
		new_valid  = cfg_q.input_valid;
		new_enable = cfg_q.input_enable;
		evt        = '0;
		if (wr_en) begin
			unique case (wr_index)
				iqt_pkg::REG_INPUT_VALID: begin
					new_valid        = bit_w;
					evt.enable_write = (bit_w != cfg_q.input_valid);
				end
				iqt_pkg::REG_INPUT_ENABLE: begin
					new_enable       = bit_w;
					evt.enable_write = (bit_w != cfg_q.input_enable);
				end
				iqt_pkg::REG_QUALIFY_DELAY:
					evt.qual_delay_write = (delay_wdata != qual_delay_q);
				iqt_pkg::REG_DISQUALIFY_DELAY:
					evt.disq_delay_write = (delay_wdata != disq_delay_q);
				default: begin
				end
			endcase
		end
		evt.enabled_after = new_valid & new_enable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q        <= '0;
			qual_delay_q <= DELAY_BITS'(iqt_pkg::DELAY_RESET);
			disq_delay_q <= DELAY_BITS'(iqt_pkg::DELAY_RESET);
		end else if (wr_en) begin
			unique case (wr_index)
				iqt_pkg::REG_INPUT_VALID:      cfg_q.input_valid      <= bit_w;
				iqt_pkg::REG_INPUT_ENABLE:     cfg_q.input_enable     <= bit_w;
				iqt_pkg::REG_NO_STANDBY_INPUT: cfg_q.no_standby_input <= bit_w;
				iqt_pkg::REG_CARD_ACTIVE:      cfg_q.card_active      <= bit_w;
				iqt_pkg::REG_CHANNEL_NUMBER:   cfg_q.channel_number   <= wr_data[3:0];
				iqt_pkg::REG_QUALIFY_DELAY:    qual_delay_q           <= delay_wdata;
				iqt_pkg::REG_DISQUALIFY_DELAY: disq_delay_q           <= delay_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg        = cfg_q;
	assign qual_delay = qual_delay_q;
	assign disq_delay = disq_delay_q;

endmodule

@@ src/iqt_step.sv @@
// Per-tick next-state and result logic: effective status, qualifier and activity counter.
`timescale 1ns / 1ps

module iqt_step #(
	parameter int DELAY_BITS = 16
) (
	input  iqt_pkg::iqt_in_t       item,
	input  iqt_pkg::iqt_cfg_t      cfg,
	input  logic [DELAY_BITS-1:0]  qual_delay,
	input  logic [DELAY_BITS-1:0]  disq_delay,
	input  iqt_pkg::iqt_state_t    state,
	input  logic [DELAY_BITS-1:0]  qual_cnt,
	input  logic [DELAY_BITS-1:0]  disq_cnt,
	output iqt_pkg::iqt_state_t    state_nxt,
	output logic [DELAY_BITS-1:0]  qual_cnt_nxt,
	output logic [DELAY_BITS-1:0]  disq_cnt_nxt,
	output iqt_pkg::iqt_out_t      result
);

	logic                 enabled;
	logic [4:0]           eff_status;
	logic [7:0]           status_ret;
	logic [7:0]           cc_a;
	logic [7:0]           cc_b;
	logic [7:0]           cc_c;
	logic [7:0]           qual_ret;
	iqt_pkg::qual_mode_t  mode_nxt;
	logic [14:0]          phase_inc;
	logic [14:0]          phase_nxt;
	logic                 phase_hit;
	logic [4:0]           status_out;

	always_comb begin
		enabled = cfg.input_valid & cfg.input_enable;
		if (!enabled)
			eff_status = iqt_pkg::ST_DISABLED;
		else if (!cfg.card_active && cfg.no_standby_input)
			eff_status = item.is_active_input ? iqt_pkg::ST_OK : iqt_pkg::ST_DISABLED;
		else
			eff_status = item.raw_status;

		if (eff_status != state.last_status) begin
			status_ret = iqt_pkg::CW_STATUS_CHG;
			cc_a       = iqt_pkg::sat_inc(state.change_count);
		end else begin
			status_ret = '0;
			cc_a       = state.change_count;
		end

		// Qualifier: returns a flag, zero, or the activity count seen so far.
		mode_nxt     = state.qual_mode;
		qual_cnt_nxt = qual_cnt;
		disq_cnt_nxt = disq_cnt;
		cc_b         = cc_a;
		qual_ret     = cc_a;
		if (!enabled || eff_status == iqt_pkg::ST_DISABLED) begin
			if (state.qual_mode != iqt_pkg::QM_IGNORE) begin
				mode_nxt = iqt_pkg::QM_IGNORE;
				qual_ret = iqt_pkg::CW_QUAL_CHG;
			end
		end else begin
			unique case (state.qual_mode)
				iqt_pkg::QM_OK: begin
					if (eff_status == iqt_pkg::ST_OK) begin
						disq_cnt_nxt = disq_delay;
					end else if (disq_cnt != '0) begin
						disq_cnt_nxt = disq_cnt - DELAY_BITS'(1);
					end else begin
						mode_nxt     = iqt_pkg::QM_DISQ;
						qual_cnt_nxt = qual_delay;
						cc_b         = iqt_pkg::sat_inc(cc_a);
						qual_ret     = iqt_pkg::CW_QUAL_CHG;
					end
				end
				iqt_pkg::QM_DISQ: begin
					if (eff_status != iqt_pkg::ST_OK) begin
						qual_cnt_nxt = qual_delay;
						qual_ret     = '0;
					end else if (qual_cnt != '0) begin
						qual_cnt_nxt = qual_cnt - DELAY_BITS'(1);
					end else begin
						mode_nxt     = iqt_pkg::QM_OK;
						disq_cnt_nxt = disq_delay;
						cc_b         = iqt_pkg::sat_inc(cc_a);
						qual_ret     = iqt_pkg::CW_QUAL_CHG;
					end
				end
				iqt_pkg::QM_IGNORE: begin
					qual_cnt_nxt = qual_delay;
					disq_cnt_nxt = disq_delay;
					mode_nxt     = iqt_pkg::QM_DISQ;
					cc_b         = iqt_pkg::sat_inc(cc_a);
					qual_ret     = iqt_pkg::CW_QUAL_CHG;
				end
				default: begin
					mode_nxt = iqt_pkg::QM_IGNORE;
					cc_b     = iqt_pkg::sat_inc(cc_a);
					qual_ret = iqt_pkg::CW_QUAL_CHG;
				end
			endcase
		end

		status_out = (mode_nxt == iqt_pkg::QM_OK) ? iqt_pkg::ST_OK : eff_status;

		// The phase counter laps from its top back to the restart point, never to zero.
		phase_inc = state.phase_count + 15'd1;
		phase_nxt = (phase_inc >= iqt_pkg::PHASE_TOP) ? iqt_pkg::PHASE_RESTART : phase_inc;
		phase_hit = ((phase_nxt & iqt_pkg::PHASE_MASK) == {3'b000, cfg.channel_number, 8'h00});

		if (phase_hit)
			cc_c = iqt_pkg::sat_inc(cc_b);
		else if (cc_b != '0)
			cc_c = cc_b - 8'd1;
		else
			cc_c = cc_b;

		state_nxt.last_status  = status_out;
		state_nxt.qual_mode    = mode_nxt;
		state_nxt.change_count = cc_c;
		state_nxt.phase_count  = phase_nxt;

		result.status      = status_out;
		result.qual_state  = mode_nxt;
		result.change_word = status_ret | qual_ret | cc_c;
	end

endmodule

@@ src/input_qualification_tick_core.sv @@
// Top level of the input qualification tick block: pipeline, state registers and config port.
`timescale 1ns / 1ps

// Input qualification tick for one timing-reference channel.
// Each transaction on the input channel (in_valid, in_stall, in_data) is one tick and
// yields exactly one result transaction on the output channel (out_valid, out_stall,
// out_data) carrying the effective status, qualifier state and change word.
// An accepted tick is captured in an input register; once the result register has room
// the qualifier logic evaluates it, updates the channel state and loads the result
// register, which offers it on the output channel.
// Throughput is one tick per cycle through a single qualifier, while out_stall is low.
// A result waiting in the output register does not block the input register, so one
// further tick is taken while the receiver stalls; in_stall rises only when both
// registers hold work, and it follows out_stall in that case.
// The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready.
// Registers must be written by the user only while the block is idle; the block does not
// enforce it. Enable and delay writes that change a value also adjust the qualifier and its
// activity counter. Reset clears both registers' valid flags, loads the default
// configuration, puts the qualifier in the ignore state with loss of signal as the last status.
module input_qualification_tick_core #(
	parameter int DELAY_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  iqt_pkg::iqt_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output iqt_pkg::iqt_out_t                 out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [iqt_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [iqt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	iqt_pkg::iqt_cfg_t      cfg;
	iqt_pkg::iqt_cfg_evt_t  evt;
	logic [DELAY_BITS-1:0]  qual_delay;
	logic [DELAY_BITS-1:0]  disq_delay;
	logic [DELAY_BITS-1:0]  delay_wdata;

	iqt_pkg::iqt_in_t       item_s1;
	logic                   valid_s1;
	iqt_pkg::iqt_out_t      out_data_q;
	logic                   out_valid_q;
	logic                   advance;

	iqt_pkg::iqt_state_t    state_q;
	logic [DELAY_BITS-1:0]  qual_cnt_q;
	logic [DELAY_BITS-1:0]  disq_cnt_q;
	iqt_pkg::iqt_state_t    state_nxt;
	logic [DELAY_BITS-1:0]  qual_cnt_nxt;
	logic [DELAY_BITS-1:0]  disq_cnt_nxt;
	iqt_pkg::iqt_out_t      result;

	assign cfg_ready = 1'b1;

	iqt_cfg #(
		.DELAY_BITS (DELAY_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (cfg_valid & cfg_ready),
		.wr_index    (cfg_index),
		.wr_data     (cfg_data),
		.cfg         (cfg),
		.qual_delay  (qual_delay),
		.disq_delay  (disq_delay),
		.delay_wdata (delay_wdata),
		.evt         (evt)
	);

	iqt_step #(
		.DELAY_BITS (DELAY_BITS)
	) u_step (
		.item         (item_s1),
		.cfg          (cfg),
		.qual_delay   (qual_delay),
		.disq_delay   (disq_delay),
		.state        (state_q),
		.qual_cnt     (qual_cnt_q),
		.disq_cnt     (disq_cnt_q),
		.state_nxt    (state_nxt),
		.qual_cnt_nxt (qual_cnt_nxt),
		.disq_cnt_nxt (disq_cnt_nxt),
		.result       (result)
	);

	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
		if (advance)
			out_data_q <= result;
	end

	// Config side effects take a tick's place; the user keeps both from coinciding, unenforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_status  <= iqt_pkg::ST_LOS;
			state_q.qual_mode    <= iqt_pkg::QM_IGNORE;
			state_q.change_count <= iqt_pkg::CC_RESET;
			state_q.phase_count  <= '0;
			qual_cnt_q           <= DELAY_BITS'(iqt_pkg::DELAY_RESET);
			disq_cnt_q           <= DELAY_BITS'(iqt_pkg::DELAY_RESET);
		end else if (evt.enable_write) begin
			state_q.change_count <= iqt_pkg::CC_ENABLE_WRITE;
			if (!evt.enabled_after)
				state_q.qual_mode <= iqt_pkg::QM_IGNORE;
		end else if (evt.qual_delay_write) begin
			state_q.change_count <= iqt_pkg::CC_DELAY_WRITE;
			if (qual_cnt_q > delay_wdata)
				qual_cnt_q <= delay_wdata;
		end else if (evt.disq_delay_write) begin
			state_q.change_count <= iqt_pkg::CC_DELAY_WRITE;
			if (disq_cnt_q > delay_wdata)
				disq_cnt_q <= delay_wdata;
		end else if (advance) begin
			state_q    <= state_nxt;
			qual_cnt_q <= qual_cnt_nxt;
			disq_cnt_q <= disq_cnt_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_qualified_reports_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.qual_state == iqt_pkg::QM_OK |-> out_data.status == iqt_pkg::ST_OK)
		else $error("qualified result does not report OK status");

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase_count < iqt_pkg::PHASE_TOP)
		else $error("phase counter beyond its lap");

	a_qual_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		qual_cnt_q <= qual_delay)
		else $error("qualify counter exceeds qualify delay");

	a_disq_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		disq_cnt_q <= disq_delay)
		else $error("disqualify counter exceeds disqualify delay");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled while the pipeline has room");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the input qualification tick block.
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_TICKS    = 110;
	localparam int TAIL_TICKS     = 300;
	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	typedef struct packed {
		logic       is_cfg;
		logic [2:0] idx;
		logic [15:0] val;
		iqt_pkg::iqt_in_t  tick;
		logic       typed;
		iqt_pkg::iqt_out_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	iqt_pkg::iqt_in_t  in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	iqt_pkg::iqt_out_t out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [iqt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [iqt_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	input_qualification_tick_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Predicted channel state, kept alongside the block
	logic        p_valid    = 1'b0;
	logic        p_enable   = 1'b0;
	logic        p_nostby   = 1'b0;
	logic        p_card_act = 1'b0;
	logic [3:0]  p_chan     = 4'd0;
	logic [15:0] p_qdly     = 16'(iqt_pkg::DELAY_RESET);
	logic [15:0] p_ddly     = 16'(iqt_pkg::DELAY_RESET);
	logic [4:0]  p_last     = iqt_pkg::ST_LOS;
	iqt_pkg::qual_mode_t p_mode = iqt_pkg::QM_IGNORE;
	logic [15:0] p_qcnt     = 16'(iqt_pkg::DELAY_RESET);
	logic [15:0] p_dcnt     = 16'(iqt_pkg::DELAY_RESET);
	logic [7:0]  p_activity = iqt_pkg::CC_RESET;
	logic [14:0] p_phase    = 15'd0;

	iqt_pkg::iqt_out_t tick_results_q[$];
	stim_row_t         dir_rows[$];
	iqt_pkg::iqt_out_t head;

	int gap_tab[4]   = '{0, 83, 0, 12};
	int stall_tab[4] = '{0, 0, 83, 12};
	int gap_pct   = 0;
	int stall_pct = 0;
	int fails     = 0;
	int quiet     = 0;
	int n_ticks   = 0;
	int n_writes  = 0;
	int n_quals   = 0;
	int n_disqs   = 0;
	bit tick_open = 1'b0;
	bit cfg_open  = 1'b0;

	function automatic void bump_activity();
		if (p_activity != 8'hff)
			p_activity = p_activity + 8'd1;
	endfunction

	function automatic void enable_changed();
		if (!(p_valid && p_enable))
			p_mode = iqt_pkg::QM_IGNORE;
		p_activity = iqt_pkg::CC_ENABLE_WRITE;
	endfunction

	function automatic void apply_reg_write(logic [2:0] idx, logic [15:0] val);
		case (idx)
			iqt_pkg::REG_INPUT_VALID: begin
				if (p_valid != val[0]) begin
					p_valid = val[0];
					enable_changed();
				end
			end
			iqt_pkg::REG_INPUT_ENABLE: begin
				if (p_enable != val[0]) begin
					p_enable = val[0];
					enable_changed();
				end
			end
			iqt_pkg::REG_NO_STANDBY_INPUT: p_nostby = val[0];
			iqt_pkg::REG_CARD_ACTIVE: p_card_act = val[0];
			iqt_pkg::REG_CHANNEL_NUMBER: p_chan = val[3:0];
			iqt_pkg::REG_QUALIFY_DELAY: begin
				if (p_qdly != val) begin
					p_qdly = val;
					if (p_qcnt > val)
						p_qcnt = val;
					p_activity = iqt_pkg::CC_DELAY_WRITE;
				end
			end
			iqt_pkg::REG_DISQUALIFY_DELAY: begin
				if (p_ddly != val) begin
					p_ddly = val;
					if (p_dcnt > val)
						p_dcnt = val;
					p_activity = iqt_pkg::CC_DELAY_WRITE;
				end
			end
			default: ;
		endcase
	endfunction

	// Returns the qualifier's contribution to the change word.
	function automatic logic [7:0] qualifier_step(logic [4:0] st);
		if (!(p_valid && p_enable) || st == iqt_pkg::ST_DISABLED) begin
			if (p_mode != iqt_pkg::QM_IGNORE) begin
				p_mode = iqt_pkg::QM_IGNORE;
				return iqt_pkg::CW_QUAL_CHG;
			end
			return p_activity;
		end
		case (p_mode)
			iqt_pkg::QM_OK: begin
				if (st == iqt_pkg::ST_OK) begin
					p_dcnt = p_ddly;
					return p_activity;
				end
				if (p_dcnt != 16'd0) begin
					p_dcnt = p_dcnt - 16'd1;
					return p_activity;
				end
				p_mode = iqt_pkg::QM_DISQ;
				p_qcnt = p_qdly;
				n_disqs++;
				bump_activity();
				return iqt_pkg::CW_QUAL_CHG;
			end
			iqt_pkg::QM_DISQ: begin
				if (st != iqt_pkg::ST_OK) begin
					p_qcnt = p_qdly;
					return 8'd0;
				end
				if (p_qcnt != 16'd0) begin
					p_qcnt = p_qcnt - 16'd1;
					return p_activity;
				end
				p_mode = iqt_pkg::QM_OK;
				p_dcnt = p_ddly;
				n_quals++;
				bump_activity();
				return iqt_pkg::CW_QUAL_CHG;
			end
			default: begin
				p_qcnt = p_qdly;
				p_dcnt = p_ddly;
				p_mode = iqt_pkg::QM_DISQ;
				bump_activity();
				return iqt_pkg::CW_QUAL_CHG;
			end
		endcase
	endfunction

	function automatic iqt_pkg::iqt_out_t predict_tick(iqt_pkg::iqt_in_t d);
		iqt_pkg::iqt_out_t r;
		logic [4:0] st;
		logic [7:0] cw;
		if (!(p_valid && p_enable))
			st = iqt_pkg::ST_DISABLED;
		else if (!p_card_act && p_nostby)
			st = d.is_active_input ? iqt_pkg::ST_OK : iqt_pkg::ST_DISABLED;
		else
			st = d.raw_status;
		cw = 8'd0;
		if (st != p_last) begin
			cw = cw | iqt_pkg::CW_STATUS_CHG;
			bump_activity();
		end
		cw = cw | qualifier_step(st);
		if (p_mode == iqt_pkg::QM_OK)
			st = iqt_pkg::ST_OK;
		p_last = st;
		p_phase = p_phase + 15'd1;
		if (p_phase >= iqt_pkg::PHASE_TOP)
			p_phase = iqt_pkg::PHASE_RESTART;
		// The periodic refresh lands whenever the phase's low twelve bits match this channel's phase.
		if ((p_phase & iqt_pkg::PHASE_MASK) == {3'b000, p_chan, 8'h00})
			bump_activity();
		else if (p_activity != 8'd0)
			p_activity = p_activity - 8'd1;
		r.status = p_last;
		r.qual_state = p_mode;
		r.change_word = cw | p_activity;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [2:0] idx, logic [15:0] val);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic stim_row_t tick_row(logic [4:0] raw, logic act);
		stim_row_t r;
		r = '0;
		r.tick.raw_status = raw;
		r.tick.is_active_input = act;
		return r;
	endfunction

	function automatic stim_row_t known_row(logic [4:0] raw, logic act, logic [4:0] st,
			iqt_pkg::qual_mode_t qm, logic [7:0] cw);
		stim_row_t r;
		r = tick_row(raw, act);
		r.typed = 1'b1;
		r.want.status = st;
		r.want.qual_state = qm;
		r.want.change_word = cw;
		return r;
	endfunction

	function automatic logic [15:0] pick_delay();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hffff;
			2, 3: return 16'($urandom_range(40, 7));
			default: return 16'($urandom_range(6, 1));
		endcase
	endfunction

	task automatic close_cfg();
		if (cfg_open) begin
			cfg_valid <= 1'b0;
			cfg_open = 1'b0;
		end
	endtask

	// Waits until every predicted result has been taken, so the block is idle.
	task automatic quiesce();
		if (tick_open) begin
			in_valid <= 1'b0;
			tick_open = 1'b0;
		end
		while (tick_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_open = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg_write(idx, val);
		n_writes++;
	endtask

	task automatic send_tick(iqt_pkg::iqt_in_t d, logic typed, iqt_pkg::iqt_out_t want);
		iqt_pkg::iqt_out_t got;
		close_cfg();
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tick_open = 1'b1;
		got = predict_tick(d);
		tick_results_q.push_back(typed ? want : got);
		n_ticks++;
	endtask

	// One run of status: a stretch of OK that may be long enough to qualify, a stretch
	// of faults that may suffice to disqualify, a disabled blip or a single noisy code.
	task automatic send_burst();
		int         kind;
		int         len;
		int         lim;
		logic [4:0] bad;
		iqt_pkg::iqt_in_t d;
		kind = $urandom_range(99);
		bad = ($urandom_range(3) == 0) ? iqt_pkg::ST_LOS : 5'($urandom_range(31, 2));
		if (kind < 40) begin
			lim = (p_qdly > 40) ? 40 : int'(p_qdly);
			len = $urandom_range(lim + 3, 1);
		end else if (kind < 70) begin
			lim = (p_ddly > 40) ? 40 : int'(p_ddly);
			len = $urandom_range(lim + 3, 1);
		end else if (kind < 85) begin
			len = 1;
		end else begin
			len = $urandom_range(3, 1);
		end
		for (int i = 0; i < len; i++) begin
			if (kind < 40)
				d.raw_status = iqt_pkg::ST_OK;
			else if (kind < 70)
				d.raw_status = bad;
			else if (kind < 85)
				d.raw_status = 5'($urandom_range(31));
			else
				d.raw_status = iqt_pkg::ST_DISABLED;
			d.is_active_input = 1'($urandom_range(1));
			send_tick(d, 1'b0, '0);
		end
	endtask

	task automatic random_config();
		logic [3:0] ch;
		case ($urandom_range(3))
			0: ch = 4'd0;
			1: ch = 4'd15;
			default: ch = 4'($urandom_range(15));
		endcase
		quiesce();
		write_reg(iqt_pkg::REG_INPUT_VALID, 16'($urandom_range(7) != 0));
		write_reg(iqt_pkg::REG_INPUT_ENABLE, 16'($urandom_range(7) != 0));
		write_reg(iqt_pkg::REG_NO_STANDBY_INPUT, 16'($urandom_range(1)));
		write_reg(iqt_pkg::REG_CARD_ACTIVE, 16'($urandom_range(1)));
		write_reg(iqt_pkg::REG_CHANNEL_NUMBER, {12'd0, ch});
		write_reg(iqt_pkg::REG_QUALIFY_DELAY, pick_delay());
		write_reg(iqt_pkg::REG_DISQUALIFY_DELAY, pick_delay());
	endtask

	task automatic load_directed();
		// Straight after reset the channel is disabled and the qualifier ignores it.
		dir_rows.push_back(known_row(5'd0, 1'b0, iqt_pkg::ST_DISABLED,
			iqt_pkg::QM_IGNORE, 8'h03));
		dir_rows.push_back(known_row(5'd31, 1'b1, iqt_pkg::ST_DISABLED,
			iqt_pkg::QM_IGNORE, 8'h01));
		dir_rows.push_back(known_row(iqt_pkg::ST_LOS, 1'b0, iqt_pkg::ST_DISABLED,
			iqt_pkg::QM_IGNORE, 8'h00));
		// Zero delays: qualify and disqualify on the first deciding tick.
		dir_rows.push_back(cfg_row(iqt_pkg::REG_INPUT_VALID, 16'd1));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_INPUT_ENABLE, 16'd1));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_QUALIFY_DELAY, 16'd0));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_DISQUALIFY_DELAY, 16'd0));
		dir_rows.push_back(tick_row(iqt_pkg::ST_OK, 1'b0));
		dir_rows.push_back(tick_row(iqt_pkg::ST_OK, 1'b1));
		dir_rows.push_back(tick_row(5'd5, 1'b0));
		dir_rows.push_back(tick_row(iqt_pkg::ST_LOS, 1'b1));
		dir_rows.push_back(tick_row(iqt_pkg::ST_OK, 1'b0));
		dir_rows.push_back(tick_row(iqt_pkg::ST_DISABLED, 1'b0));
		dir_rows.push_back(tick_row(iqt_pkg::ST_OK, 1'b1));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_QUALIFY_DELAY, 16'd3));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_DISQUALIFY_DELAY, 16'd2));
		for (int i = 0; i < 5; i++)
			dir_rows.push_back(tick_row(iqt_pkg::ST_OK, 1'(i)));
		dir_rows.push_back(tick_row(5'd31, 1'b1));
		dir_rows.push_back(tick_row(5'd17, 1'b0));
		dir_rows.push_back(tick_row(5'd3, 1'b1));
		dir_rows.push_back(tick_row(iqt_pkg::ST_OK, 1'b0));
		// A standby card follows only the active-input flag for such a channel.
		dir_rows.push_back(cfg_row(iqt_pkg::REG_NO_STANDBY_INPUT, 16'd1));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_CARD_ACTIVE, 16'd0));
		dir_rows.push_back(tick_row(5'd9, 1'b1));
		dir_rows.push_back(tick_row(5'd9, 1'b0));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_CARD_ACTIVE, 16'd1));
		dir_rows.push_back(tick_row(5'd4, 1'b0));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_CHANNEL_NUMBER, 16'd15));
		dir_rows.push_back(cfg_row(REG_UNMAPPED, 16'hffff));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_QUALIFY_DELAY, 16'hffff));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_DISQUALIFY_DELAY, 16'hffff));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_INPUT_ENABLE, 16'd0));
		dir_rows.push_back(tick_row(iqt_pkg::ST_OK, 1'b1));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_INPUT_VALID, 16'd0));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_INPUT_ENABLE, 16'd1));
		dir_rows.push_back(tick_row(iqt_pkg::ST_OK, 1'b0));
		dir_rows.push_back(cfg_row(iqt_pkg::REG_INPUT_VALID, 16'd1));
		dir_rows.push_back(tick_row(iqt_pkg::ST_OK, 1'b0));
	endtask

	// Result checking, receiver stalls and the watchdog.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (tick_results_q.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("unexpected result: status=%0d qual=%0d change=%02h",
							out_data.status, out_data.qual_state, out_data.change_word);
				end else begin
					head = tick_results_q.pop_front();
					if (out_data.status !== head.status ||
							out_data.qual_state !== head.qual_state ||
							out_data.change_word !== head.change_word) begin
						fails++;
						if (fails <= MAX_REPORTS)
							$display("mismatch at %0t: want %0d/%0d/%02h, got %0d/%0d/%02h",
								$realtime, head.status, head.qual_state,
								head.change_word, out_data.status,
								out_data.qual_state, out_data.change_word);
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			out_stall <= ($urandom_range(99) < stall_pct);
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		load_directed();
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				quiesce();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_config();
			gap_pct = gap_tab[ph % 4];
			stall_pct = stall_tab[ph % 4];
			target = n_ticks + PHASE_TICKS;
			while (n_ticks < target)
				send_burst();
		end

		// Finish with a stretch at full rate on an enabled channel with short delays.
		quiesce();
		gap_pct = 0;
		stall_pct = 0;
		write_reg(iqt_pkg::REG_INPUT_VALID, 16'd1);
		write_reg(iqt_pkg::REG_INPUT_ENABLE, 16'd1);
		write_reg(iqt_pkg::REG_CARD_ACTIVE, 16'd1);
		write_reg(iqt_pkg::REG_CHANNEL_NUMBER, 16'($urandom_range(15)));
		write_reg(iqt_pkg::REG_QUALIFY_DELAY, 16'($urandom_range(5)));
		write_reg(iqt_pkg::REG_DISQUALIFY_DELAY, 16'($urandom_range(5)));
		target = n_ticks + TAIL_TICKS;
		while (n_ticks < target)
			send_burst();

		quiesce();
		close_cfg();
		repeat (8) @(posedge clk);
		if (tick_results_q.size() != 0)
			fails++;

		$display("Ran %0d ticks and %0d register writes under varied idling.",
			n_ticks, n_writes);
		$display("Saw %0d qualifications and %0d disqualifications; %0d failures.",
			n_quals, n_disqs, fails);
		if (fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
